// File: hdl/psrq_pkg.sv
// Shared types and constants of the paced segment release queue.
package psrq_pkg;

  localparam int unsigned TAG_W       = 16;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned TOT_W       = 21;
  localparam int unsigned CNT_OUT_W   = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 21;

  localparam logic [DUR_W-1:0] DEFAULT_FALLBACK_MS = 16'd1000;
  localparam logic [TOT_W-1:0] TOTAL_MAX           = 21'h1FFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REL,
    ST_FL_RD,
    ST_FL_OUT
  } state_e;

  typedef struct packed {
    logic [DUR_W-1:0] fallback_ms;  // already mapped: zero reads as the default
    logic [TOT_W-1:0] startup_ms;
    logic [TOT_W-1:0] recovery_ms;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] dur;
  } entry_t;

endpackage

// File: hdl/psrq_cfg.sv
// Configuration registers of the paced segment release queue.
module psrq_cfg
  import psrq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [DUR_W-1:0] fallback_q;
  logic [TOT_W-1:0] startup_q;
  logic [TOT_W-1:0] recovery_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= DEFAULT_FALLBACK_MS;
      startup_q  <= '0;
      recovery_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FALLBACK: fallback_q <= cfg_wdata_i[DUR_W-1:0];
        REG_STARTUP:  startup_q  <= cfg_wdata_i[TOT_W-1:0];
        REG_RECOVERY: recovery_q <= cfg_wdata_i[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  // A programmed fallback of zero stands for the default interval.
  assign cfg_o.fallback_ms = (fallback_q == '0) ? DEFAULT_FALLBACK_MS : fallback_q;
  assign cfg_o.startup_ms  = startup_q;
  assign cfg_o.recovery_ms = recovery_q;

endmodule

// File: hdl/psrq_ring.sv
// Segment ring memory: one write port, one registered read port.
module psrq_ring
  import psrq_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/paced_segment_release_queue.sv
// Top level of the paced segment release queue: pacing control and output register.
//
// A FIFO pacer for media segments held in a ring memory of QUEUE_DEPTH entries.
// A push word stores a tag and its effective duration (zero selects the fallback
// interval) and adds that duration to a saturating buffered total; a tick word
// counts the release countdown down by one millisecond. Releases start once the
// buffered total reaches the startup threshold, or the recovery threshold after
// anything has been released; the first segment then goes out at once and each
// next one after as many ticks as the previous one lasted. A push or tick that
// releases nothing is done at once; one that releases a segment also waits in
// the release state for the head entry, which comes back from the registered
// ring read, and stays there while the output register is still occupied. A
// flush word stops the block for good and drains the ring in order, each segment
// by a ring read and then an output load, marking the last word. Input words are
// accepted while an earlier result still waits at the output. The ring needs no
// clearing pass: only queued entries are ever read. queue_count_o is six bits
// wide, which covers depths up to 63.
module paced_segment_release_queue
  import psrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            opcode_i,
  input  logic [TAG_W-1:0]      seg_tag_i,
  input  logic [DUR_W-1:0]      seg_duration_ms_i,
  // Output channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TAG_W-1:0]      out_tag_o,
  output logic [DUR_W-1:0]      out_duration_ms_o,
  output logic                  from_flush_o,
  output logic                  flush_last_o,
  output logic [CNT_OUT_W-1:0]  queue_count_o,
  output logic [TOT_W-1:0]      buffered_ms_o,
  output logic                  overflow_seen_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t cfg;

  psrq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Control state.
  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic [DUR_W-1:0] cd_q, cd_d;
  logic             primed_q, primed_d;
  logic             rel_before_q, rel_before_d;
  logic             halted_q, halted_d;
  logic             ovf_q, ovf_d;
  logic             fwd_q, fwd_d;
  entry_t           fwd_entry_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [TAG_W-1:0] out_tag_q, out_tag_d;
  logic [DUR_W-1:0] out_dur_q, out_dur_d;
  logic             out_fl_q, out_fl_d;
  logic             out_last_q, out_last_d;
  logic [CW-1:0]    out_cnt_q, out_cnt_d;
  logic [TOT_W-1:0] out_tot_q, out_tot_d;
  logic             out_ovf_q, out_ovf_d;

  // Ring access.
  logic             ring_we, ring_re;
  logic [AW-1:0]    tail_addr;
  entry_t           push_entry, rd_entry, pop_entry;

  logic             in_accept, slot_free, full, push_ok, release_now;
  logic [DUR_W-1:0] eff_dur;
  logic [TOT_W:0]   sum_tot;
  logic [TOT_W-1:0] sat_tot, need, p_tot, pop_tot, pop_sub;
  logic [CW-1:0]    p_cnt, cnt_dec;
  logic [DUR_W-1:0] p_cd;
  logic             p_primed;
  logic [AW:0]      tail_sum;
  logic [AW-1:0]    head_inc;
  op_e              op;

  assign op         = op_e'(opcode_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign full     = (cnt_q == CW'(QUEUE_DEPTH));
  assign eff_dur  = (seg_duration_ms_i == '0) ? cfg.fallback_ms : seg_duration_ms_i;
  assign sum_tot  = {1'b0, tot_q} + (TOT_W+1)'(eff_dur);
  assign sat_tot  = sum_tot[TOT_W] ? TOTAL_MAX : sum_tot[TOT_W-1:0];
  assign need     = rel_before_q ? cfg.recovery_ms : cfg.startup_ms;

  // Tail address is head plus count, wrapped at the ring depth.
  assign tail_sum  = (AW+1)'(head_q) + (AW+1)'(cnt_q);
  assign tail_addr = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
  assign head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign cnt_dec   = cnt_q - CW'(1);

  assign push_entry.tag = seg_tag_i;
  assign push_entry.dur = eff_dur;

  // A segment pushed into an empty ring is also the head read in the same
  // cycle, so its word is forwarded instead of taken from the ring.
  assign pop_entry = fwd_q ? fwd_entry_q : rd_entry;
  assign pop_sub   = (TOT_W'(pop_entry.dur) < tot_q) ? TOT_W'(pop_entry.dur) : tot_q;
  assign pop_tot   = tot_q - pop_sub;

  assign push_ok = in_accept && !halted_q && (op == OP_PUSH) && !full;
  assign ring_we = push_ok;

  psrq_ring #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(tail_addr),
    .wdata_i(push_entry),
    .re_i   (ring_re),
    .raddr_i(head_q),
    .rdata_o(rd_entry)
  );

  // Pacing check on the state as a push or tick leaves it.
  always_comb begin
    p_cnt       = cnt_q;
    p_tot       = tot_q;
    p_cd        = cd_q;
    p_primed    = primed_q;
    release_now = 1'b0;
    if (op == OP_PUSH) begin
      if (!full) begin
        p_cnt = cnt_q + CW'(1);
        p_tot = sat_tot;
      end
    end else if (cd_q != '0) begin
      p_cd = cd_q - DUR_W'(1);
    end
    if (p_cnt == '0) begin
      p_primed = 1'b0;
    end else if (!primed_q) begin
      if (p_tot >= need) begin
        p_primed    = 1'b1;
        p_cd        = '0;
        release_now = 1'b1;
      end
    end else if (p_cd == '0) begin
      release_now = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    tot_d        = tot_q;
    cd_d         = cd_q;
    primed_d     = primed_q;
    rel_before_d = rel_before_q;
    halted_d     = halted_q;
    ovf_d        = ovf_q;
    fwd_d        = fwd_q;
    ring_re      = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_tag_d    = out_tag_q;
    out_dur_d    = out_dur_q;
    out_fl_d     = out_fl_q;
    out_last_d   = out_last_q;
    out_cnt_d    = out_cnt_q;
    out_tot_d    = out_tot_q;
    out_ovf_d    = out_ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && !halted_q) begin
          case (op)
            OP_PUSH, OP_TICK: begin
              cnt_d    = p_cnt;
              tot_d    = p_tot;
              cd_d     = p_cd;
              primed_d = p_primed;
              if ((op == OP_PUSH) && full) begin
                ovf_d = 1'b1;
              end
              if (release_now) begin
                ring_re = 1'b1;
                fwd_d   = push_ok && (cnt_q == '0);
                state_d = ST_REL;
              end
            end
            OP_FLUSH: begin
              halted_d = 1'b1;
              tot_d    = '0;
              primed_d = 1'b0;
              if (cnt_q != '0) begin
                state_d = ST_FL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REL: begin
        // Retire the head once the output register can take its word.
        if (slot_free) begin
          head_d       = head_inc;
          cnt_d        = cnt_dec;
          tot_d        = pop_tot;
          cd_d         = pop_entry.dur;
          rel_before_d = 1'b1;
          if (cnt_dec == '0) begin
            primed_d = 1'b0;
          end
          out_valid_d = 1'b1;
          out_tag_d   = pop_entry.tag;
          out_dur_d   = pop_entry.dur;
          out_fl_d    = 1'b0;
          out_last_d  = 1'b0;
          out_cnt_d   = cnt_dec;
          out_tot_d   = pop_tot;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        ring_re = 1'b1;
        fwd_d   = 1'b0;
        head_d  = head_inc;
        cnt_d   = cnt_dec;
        state_d = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_tag_d   = rd_entry.tag;
          out_dur_d   = rd_entry.dur;
          out_fl_d    = 1'b1;
          out_last_d  = (cnt_q == '0);
          out_cnt_d   = cnt_q;
          out_tot_d   = '0;
          out_ovf_d   = ovf_q;
          state_d     = (cnt_q != '0) ? ST_FL_RD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      cnt_q        <= '0;
      tot_q        <= '0;
      cd_q         <= '0;
      primed_q     <= 1'b0;
      rel_before_q <= 1'b0;
      halted_q     <= 1'b0;
      ovf_q        <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      tot_q        <= tot_d;
      cd_q         <= cd_d;
      primed_q     <= primed_d;
      rel_before_q <= rel_before_d;
      halted_q     <= halted_d;
      ovf_q        <= ovf_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_entry_q <= push_entry;
    end
    out_tag_q  <= out_tag_d;
    out_dur_q  <= out_dur_d;
    out_fl_q   <= out_fl_d;
    out_last_q <= out_last_d;
    out_cnt_q  <= out_cnt_d;
    out_tot_q  <= out_tot_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_tag_o         = out_tag_q;
  assign out_duration_ms_o = out_dur_q;
  assign from_flush_o      = out_fl_q;
  assign flush_last_o      = out_last_q;
  assign queue_count_o     = CNT_OUT_W'(out_cnt_q);
  assign buffered_ms_o     = out_tot_q;
  assign overflow_seen_o   = out_ovf_q;

  // The ring never holds more segments than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("segment count exceeds ring depth");

  // A paced release only happens on a running block with a queued segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL) |-> (!halted_q && (cnt_q != '0)))
    else $error("paced release without a queued segment or after flush");

  // A flush of a nonempty ring starts draining in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !halted_q && (op == OP_FLUSH) && (cnt_q != '0))
      |=> (state_q == ST_FL_RD) && halted_q)
    else $error("flush did not start draining");

  // The final flush word leaves the ring empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flush_last_o) |-> (from_flush_o && (cnt_q == '0)))
    else $error("flush marked last with segments still queued");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the paced segment release queue, with its own pacing predictor.
module tb;
  import psrq_pkg::*;

  localparam int unsigned DEPTH        = 32;
  // Cycles to let pass after the last expected release before the block counts as idle.
  // That covers the ring read and output load that a release or a flushed segment goes through.
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  // Filler segment used to reach the threshold while draining; it covers every
  // recovery threshold of the random phases.
  localparam logic [DUR_W-1:0] FILL_MS = 16'd40;

  // One released segment as it shows up on the output channel.
  typedef struct {
    logic [TAG_W-1:0]     tag;
    logic [DUR_W-1:0]     dur;
    logic                 from_flush;
    logic                 last_one;
    logic [CNT_OUT_W-1:0] count;
    logic [TOT_W-1:0]     buffered;
    logic                 overflow;
  } release_t;

  // Keeps a copy of the queue, the buffered total and the pacing state, works out
  // the releases that each accepted word causes and checks the block's releases
  // against them in order.
  class release_ledger;
    logic [DUR_W-1:0] fallback_ms = DEFAULT_FALLBACK_MS;
    logic [TOT_W-1:0] startup_ms  = '0;
    logic [TOT_W-1:0] recovery_ms = '0;
    logic [TAG_W-1:0] tag_ring [DEPTH];
    logic [DUR_W-1:0] dur_ring [DEPTH];
    int unsigned      head = 0;
    int unsigned      count = 0;
    logic [TOT_W-1:0] total = '0;
    logic [DUR_W-1:0] countdown = '0;
    bit               primed = 0;
    bit               released_once = 0;
    bit               halted = 0;
    bit               overflow = 0;
    release_t         due[$];
    int unsigned      words = 0;
    int unsigned      dropped = 0;
    int unsigned      checked = 0;
    int unsigned      flushed = 0;
    int unsigned      errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FALLBACK: fallback_ms = data[DUR_W-1:0];
        REG_STARTUP:  startup_ms = data[TOT_W-1:0];
        REG_RECOVERY: recovery_ms = data[TOT_W-1:0];
        default: ;
      endcase
    endfunction

    function void pop_head(output logic [TAG_W-1:0] tag, output logic [DUR_W-1:0] dur);
      tag = tag_ring[head];
      dur = dur_ring[head];
      head = (head + 1) % DEPTH;
      count--;
    endfunction

    function void emit(logic [TAG_W-1:0] tag, logic [DUR_W-1:0] dur, bit from_flush,
                       bit last_one);
      release_t r;
      r.tag        = tag;
      r.dur        = dur;
      r.from_flush = from_flush;
      r.last_one   = last_one;
      r.count      = CNT_OUT_W'(count);
      r.buffered   = total;
      r.overflow   = overflow;
      due.insert(due.size(), r);
    endfunction

    // Pacing decision made after every push and tick: at most one release.
    function void try_release();
      logic [TAG_W-1:0] tag;
      logic [DUR_W-1:0] dur;
      logic [TOT_W-1:0] need;
      if (count == 0) begin
        primed = 0;
        return;
      end
      if (!primed) begin
        need = released_once ? recovery_ms : startup_ms;
        if (total < need) return;
        primed = 1;
        countdown = '0;
      end
      if (countdown != 0) return;
      pop_head(tag, dur);
      total = (dur < total) ? total - dur : '0;
      countdown = dur;
      released_once = 1;
      if (count == 0) primed = 0;
      emit(tag, dur, 1'b0, 1'b0);
    endfunction

    function void note_word(op_e op, logic [TAG_W-1:0] tag, logic [DUR_W-1:0] dur);
      logic [TOT_W:0]   grown;
      logic [DUR_W-1:0] eff;
      logic [TAG_W-1:0] ftag;
      words++;
      if (halted) return;
      case (op)
        OP_PUSH: begin
          if (count >= DEPTH) begin
            overflow = 1;
            dropped++;
          end else begin
            eff = (dur != 0) ? dur :
                  ((fallback_ms != 0) ? fallback_ms : DEFAULT_FALLBACK_MS);
            tag_ring[(head + count) % DEPTH] = tag;
            dur_ring[(head + count) % DEPTH] = eff;
            count++;
            grown = total + eff;
            total = (grown > TOTAL_MAX) ? TOTAL_MAX : grown[TOT_W-1:0];
          end
          try_release();
        end
        OP_TICK: begin
          if (countdown != 0) countdown = countdown - 1'b1;
          try_release();
        end
        OP_FLUSH: begin
          // The total is cleared before the queue drains, so every flushed
          // segment reports zero buffered time.
          halted = 1;
          total = '0;
          primed = 0;
          while (count != 0) begin
            pop_head(ftag, eff);
            emit(ftag, eff, 1'b1, count == 0);
            flushed++;
          end
        end
        default: ;
      endcase
    endfunction

    function bit differs(string field, logic [31:0] want, logic [31:0] got);
      if (want === got) return 0;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      return 1;
    endfunction

    function void check_release(release_t got);
      release_t want;
      bit       bad;
      if (due.size() == 0) begin
        $display("%0t: release of tag %0d arrived with none expected", $time, got.tag);
        errors++;
        return;
      end
      want = due[0];
      due.delete(0);
      checked++;
      bad = 0;
      bad |= differs("out_tag", 32'(want.tag), 32'(got.tag));
      bad |= differs("out_duration_ms", 32'(want.dur), 32'(got.dur));
      bad |= differs("from_flush", 32'(want.from_flush), 32'(got.from_flush));
      bad |= differs("flush_last", 32'(want.last_one), 32'(got.last_one));
      bad |= differs("queue_count", 32'(want.count), 32'(got.count));
      bad |= differs("buffered_ms", 32'(want.buffered), 32'(got.buffered));
      bad |= differs("overflow_seen", 32'(want.overflow), 32'(got.overflow));
      if (bad) errors++;
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_FALLBACK;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic [1:0]            opcode = OP_TICK;
  logic [TAG_W-1:0]      seg_tag = '0;
  logic [DUR_W-1:0]      seg_dur = '0;
  logic                  out_stall = 1'b0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [TAG_W-1:0]      out_tag_o;
  logic [DUR_W-1:0]      out_duration_ms_o;
  logic                  from_flush_o;
  logic                  flush_last_o;
  logic [CNT_OUT_W-1:0]  queue_count_o;
  logic [TOT_W-1:0]      buffered_ms_o;
  logic                  overflow_seen_o;

  release_ledger ledger;

  // Idle percentages of the two sides, changed from phase to phase.
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  // A long receiver hold-off is requested by bumping hold_seq; the receiver
  // process counts the stretch down on its own.
  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned held_seq = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  paced_segment_release_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode),
    .seg_tag_i        (seg_tag),
    .seg_duration_ms_i(seg_dur),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_tag_o        (out_tag_o),
    .out_duration_ms_o(out_duration_ms_o),
    .from_flush_o     (from_flush_o),
    .flush_last_o     (flush_last_o),
    .queue_count_o    (queue_count_o),
    .buffered_ms_o    (buffered_ms_o),
    .overflow_seen_o  (overflow_seen_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: a requested hold-off keeps stall high for its whole length,
  // otherwise stall is drawn afresh every cycle.
  always @(posedge clk_i) begin
    if (hold_seq != held_seq) begin
      held_seq = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Monitor: everything is sampled at the rising edge, before any of the
  // updates made at that edge land, so the values seen are the handshake's.
  always @(posedge clk_i) begin : monitor
    release_t seen;
    if (rst_ni) begin
      if (cfg_we) ledger.set_reg(cfg_idx, cfg_wdata);
      if (in_valid && !in_stall_o) ledger.note_word(op_e'(opcode), seg_tag, seg_dur);
      if (out_valid_o && !out_stall) begin
        seen.tag        = out_tag_o;
        seen.dur        = out_duration_ms_o;
        seen.from_flush = from_flush_o;
        seen.last_one   = flush_last_o;
        seen.count      = queue_count_o;
        seen.buffered   = buffered_ms_o;
        seen.overflow   = overflow_seen_o;
        ledger.check_release(seen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d releases still due", cycles, ledger.due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one word and returns at the edge that accepts it. Valid stays high
  // when the next word follows at once; otherwise it drops for a random gap.
  task automatic send_word(op_e op, logic [TAG_W-1:0] tag, logic [DUR_W-1:0] dur);
    int unsigned gap;
    in_valid <= 1'b1;
    opcode   <= op;
    seg_tag  <= tag;
    seg_dur  <= dur;
    do @(posedge clk_i); while (in_stall_o);
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic stop_words();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for every expected release, then for the block's own latency, so
  // that a word that released nothing has surely been dealt with too.
  task automatic wait_idle();
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register writes leave the enable high so that back-to-back writes need
  // no second assignment in one step; end_writes lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Ticks until the predicted queue is empty, so the next phase starts from an
  // unprimed block. A queue still waiting for its threshold first gets a filler
  // segment long enough to meet it. Ticks carry random, ignored tag and
  // duration fields.
  task automatic drain_queue();
    stop_words();
    while (ledger.count != 0) begin
      if (!ledger.primed)
        send_word(OP_PUSH, 16'($urandom_range(65535)), FILL_MS);
      else
        send_word(OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
    end
    stop_words();
  endtask

  // Random pushes and ticks. Pushes are favored while the queue is short and
  // ticks while it is long, so pacing keeps running. Durations are mostly
  // short so countdowns expire within a phase.
  task automatic run_random(int unsigned n);
    int unsigned      pick;
    int unsigned      push_pct;
    logic [DUR_W-1:0] dur;
    for (int unsigned k = 0; k < n; k++) begin
      push_pct = (ledger.count < 6) ? 60 : ((ledger.count < 28) ? 30 : 8);
      pick = $urandom_range(99);
      if (pick < 10) dur = '0;
      else if (pick < 80) dur = 16'd1;
      else if (pick < 95) dur = 16'($urandom_range(4, 2));
      else dur = 16'($urandom_range(12, 5));
      if ($urandom_range(99) < push_pct)
        send_word(OP_PUSH, 16'($urandom_range(65535)), dur);
      else
        send_word(OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      // Now and then the sender waits for every due release to arrive.
      if ($urandom_range(59) == 0) begin
        stop_words();
        wait_idle();
      end
    end
  endtask

  initial begin
    int unsigned errors;
    ledger = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender idling often and receiver nearly always. Startup
    // needs 9 ms, recovery 6 ms, and a zero duration stands for 2 ms.
    src_idle_pct  = 36;
    sink_idle_pct = 85;
    write_reg(REG_FALLBACK, 21'd2);
    write_reg(REG_STARTUP, 21'd9);
    write_reg(REG_RECOVERY, 21'd6);
    end_writes();
    send_word(OP_TICK, 16'h0000, 16'h0000);     // tick on an empty queue
    send_word(OP_PUSH, 16'h0000, 16'h0000);     // zero duration takes the fallback
    send_word(OP_PUSH, 16'hFFFF, 16'd3);
    send_word(OP_PUSH, 16'h1234, 16'd3);        // 8 ms buffered, still below startup
    send_word(OP_TICK, 16'hFFFF, 16'hFFFF);
    send_word(OP_PUSH, 16'h00FF, 16'd1);        // reaches startup: head goes out at once
    send_word(OP_TICK, 16'h0000, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000);     // 2 ms later the second segment
    repeat (3) send_word(OP_TICK, 16'h5A5A, 16'hA5A5);
    repeat (3) send_word(OP_TICK, 16'hA5A5, 16'h5A5A);
    // The queue ran empty, so the recovery threshold now applies.
    send_word(OP_PUSH, 16'h8001, 16'd2);
    send_word(OP_PUSH, 16'h4002, 16'hFFFF);     // largest duration crosses recovery
    send_word(OP_TICK, 16'h0000, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000);
    stop_words();
    wait_idle();

    // Recovery at zero: every push on an empty queue releases at once. The
    // receiver holds off for a long stretch while pushes keep coming, which
    // fills the output and stalls the input.
    write_reg(REG_FALLBACK, 21'd1);
    write_reg(REG_RECOVERY, 21'd0);
    end_writes();
    hold_len = 150;
    hold_seq++;
    repeat (16) send_word(OP_PUSH, 16'($urandom_range(65535)), 16'($urandom_range(3, 0)));
    run_random(55);
    drain_queue();
    wait_idle();

    // The other way round: sender mostly idle, receiver rarely.
    src_idle_pct  = 85;
    sink_idle_pct = 36;
    write_reg(REG_FALLBACK, 21'd5);
    write_reg(REG_RECOVERY, 21'd20);
    end_writes();
    run_random(50);
    drain_queue();
    wait_idle();

    // No idling on either side.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_reg(REG_FALLBACK, 21'd1);
    write_reg(REG_STARTUP, 21'd0);
    write_reg(REG_RECOVERY, 21'd30);
    end_writes();
    run_random(35);
    drain_queue();
    wait_idle();

    // Thresholds at their maximum hold every segment back; a fallback of zero
    // means 1000 ms. The queue fills, later pushes are dropped, and the flush
    // then hands out all 32 segments.
    write_reg(REG_FALLBACK, 21'd0);
    write_reg(REG_STARTUP, 21'h1FFFFF);
    write_reg(REG_RECOVERY, 21'h1FFFFF);
    end_writes();
    for (int unsigned k = 0; k < 16; k++) begin
      if (k % 4 == 3)
        send_word(OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      else
        send_word(OP_PUSH, 16'($urandom_range(65535)),
                  (k % 2 != 0) ? 16'd0 : 16'($urandom));
    end
    stop_words();
    wait_idle();
    write_reg(REG_FALLBACK, 21'd65535);
    end_writes();
    for (int unsigned k = 0; k < 24; k++) begin
      case (k % 3)
        0: send_word(OP_PUSH, 16'($urandom_range(65535)), 16'd0);
        1: send_word(OP_PUSH, 16'($urandom_range(65535)), 16'hFFFF);
        default: send_word(OP_PUSH, 16'($urandom_range(65535)), 16'($urandom));
      endcase
    end
    send_word(OP_FLUSH, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
    // Once flushed the block is stopped for good and ignores everything.
    send_word(OP_PUSH, 16'h7777, 16'd5);
    send_word(OP_TICK, 16'h0000, 16'h0000);
    send_word(OP_FLUSH, 16'h0000, 16'h0000);
    stop_words();
    wait_idle();

    errors = ledger.errors;
    if (ledger.due.size() != 0) begin
      $display("%0d expected releases never arrived", ledger.due.size());
      errors += ledger.due.size();
    end
    $display("Covered %0d words under six register settings, %0d pushes dropped on a full queue.",
             ledger.words, ledger.dropped);
    $display("Checked %0d releases, %0d of them from the final flush.",
             ledger.checked, ledger.flushed);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
